// File: hw/rtl/wmf_pkg.sv
package wmf_pkg;

  localparam int PIX_W    = 8;
  localparam int WIN      = 7;            // widest window side the sorter holds
  localparam int NELEM    = WIN * WIN;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_POS_W = 10;
  localparam int ROW_W    = 10;
  localparam int FIFO_DEPTH = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_WINDOW = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN-1:0] column_t;      // [row offset back from newest]
  typedef column_t [WIN-1:0] window_t;   // [column offset back from newest]
  typedef pix_t [NELEM-1:0] elems_t;

  typedef struct packed {
    logic                 border;
    logic [OUT_POS_W-1:0] col;
    logic [OUT_POS_W-1:0] row;
    logic                 last;
  } meta_t;

  typedef struct packed {
    pix_t                 value;
    logic [OUT_POS_W-1:0] col;
    logic [OUT_POS_W-1:0] row;
    logic                 last;
  } result_t;

  // rank of the median within (2h+1)^2 values
  function automatic logic [5:0] median_rank(input logic [1:0] h);
    logic [5:0] r;
    case (h)
      2'd0:    r = 6'd0;
      2'd1:    r = 6'd4;
      2'd2:    r = 6'd12;
      default: r = 6'd24;
    endcase
    return r;
  endfunction

  // elements taking part: column and row offsets both within 2h
  function automatic logic [NELEM-1:0] window_mask(input logic [1:0] h);
    logic [NELEM-1:0] m;
    m = '0;
    for (int dc = 0; dc < WIN; dc++) begin
      for (int dr = 0; dr < WIN; dr++) begin
        m[dc*WIN+dr] = (dc <= 2*int'(h)) && (dr <= 2*int'(h));
      end
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/wmf_front.sv
module wmf_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wmf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wmf_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          accept_i,
  input  wmf_pkg::pix_t                 pixel_i,
  output logic                          emit_now_o,
  output logic                          col_valid_o,
  output wmf_pkg::column_t              col_o,
  output logic                          emit_o,
  output wmf_pkg::meta_t                meta_o,
  output logic [1:0]                    half_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int NBANK = MAX_WINDOW;
  localparam int RMW   = $clog2(MAX_WINDOW);
  // the sorter holds at most a seven by seven window
  localparam int HMAX  = ((MAX_WINDOW - 1) / 2 > 3) ? 3 : (MAX_WINDOW - 1) / 2;

  logic [wmf_pkg::CFG_W-1:0] width_q, height_q;
  logic [2:0]                wsize_q;
  logic [CW-1:0]             col_q, col_d;
  logic [wmf_pkg::ROW_W-1:0] row_q, row_d;
  logic [RMW-1:0]            rmod_q, rmod_d;

  logic [CW:0]               eff_w;
  logic [wmf_pkg::CFG_W-1:0] eff_h;
  logic [1:0]                half;
  logic                      emit, border, last, col_end;
  logic [CW-1:0]             oc;
  logic [wmf_pkg::ROW_W-1:0] orow;

  logic                      s1_valid_q, s1_emit_q;
  wmf_pkg::pix_t             s1_pix_q;
  logic [RMW-1:0]            s1_rmod_q;
  wmf_pkg::meta_t            s1_meta_q;
  wmf_pkg::pix_t             rd_q [NBANK];

  always_comb begin
    int unsigned wv, hv;
    logic [CW:0]               ocx, wxc;
    logic [wmf_pkg::CFG_W-1:0] orx, wxr;
    wv = width_q;
    if (wv == 0) wv = 1;
    if (wv > MAX_WIDTH) wv = MAX_WIDTH;
    hv = height_q;
    if (hv == 0) hv = 1;
    if (hv > 1024) hv = 1024;
    eff_w = (CW+1)'(wv);
    eff_h = wmf_pkg::CFG_W'(hv);
    if (int'(wsize_q >> 1) > HMAX) half = 2'(HMAX);
    else half = 2'(wsize_q >> 1);

    emit = (col_q >= CW'(half)) && (row_q >= wmf_pkg::ROW_W'(half));
    oc   = col_q - CW'(half);
    orow = row_q - wmf_pkg::ROW_W'(half);
    ocx  = {1'b0, oc};
    wxc  = (CW+1)'(wsize_q);
    orx  = {1'b0, orow};
    wxr  = wmf_pkg::CFG_W'(wsize_q);
    border = (ocx < wxc) || (ocx + wxc >= eff_w) || (orx < wxr) || (orx + wxr >= eff_h);
    col_end = ({1'b0, col_q} == eff_w - 1'b1);
    last = col_end && ({1'b0, row_q} == eff_h - 1'b1);

    col_d  = col_q;
    row_d  = row_q;
    rmod_d = rmod_q;
    if (cfg_we_i && cfg_idx_i != wmf_pkg::CFG_NONE) begin
      col_d  = '0;
      row_d  = '0;
      rmod_d = '0;
    end else if (accept_i) begin
      if (col_end) begin
        col_d = '0;
        if ({1'b0, row_q} == eff_h - 1'b1) begin
          row_d  = '0;
          rmod_d = '0;
        end else begin
          row_d  = row_q + 1'b1;
          rmod_d = (rmod_q == RMW'(NBANK-1)) ? '0 : rmod_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= wmf_pkg::CFG_W'(512);
      height_q   <= wmf_pkg::CFG_W'(512);
      wsize_q    <= 3'd5;
      col_q      <= '0;
      row_q      <= '0;
      rmod_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wmf_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
          wmf_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          wmf_pkg::CFG_WINDOW: wsize_q  <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      col_q      <= col_d;
      row_q      <= row_d;
      rmod_q     <= rmod_d;
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_emit_q        <= emit;
      s1_pix_q         <= pixel_i;
      s1_rmod_q        <= rmod_q;
      s1_meta_q.border <= border;
      s1_meta_q.col    <= wmf_pkg::OUT_POS_W'(oc);
      s1_meta_q.row    <= orow;
      s1_meta_q.last   <= last;
    end
  end

  // one bank per row modulo the store depth, read at the incoming column
  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    wmf_pkg::pix_t mem [MAX_WIDTH];
    always_ff @(posedge clk_i) begin
      if (accept_i && rmod_q == RMW'(b)) mem[col_q] <= pixel_i;
      rd_q[b] <= mem[col_q];
    end
  end

  always_comb begin
    int unsigned t;
    col_o[0] = s1_pix_q;
    for (int d = 1; d < wmf_pkg::WIN; d++) begin
      t = int'(s1_rmod_q) + NBANK - (d % NBANK);
      if (t >= NBANK) t = t - NBANK;
      col_o[d] = rd_q[RMW'(t)];
    end
  end

  assign emit_now_o  = emit;
  assign col_valid_o = s1_valid_q;
  assign emit_o      = s1_emit_q;
  assign meta_o      = s1_meta_q;
  assign half_o      = half;

endmodule

// File: hw/rtl/wmf_median.sv
module wmf_median (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             col_valid_i,
  input  wmf_pkg::column_t col_i,
  input  logic             emit_i,
  input  wmf_pkg::meta_t   meta_i,
  input  logic [1:0]       half_i,
  output logic             res_valid_o,
  output wmf_pkg::result_t res_o
);

  localparam int NST = wmf_pkg::PIX_W;

  wmf_pkg::window_t win_q;
  logic             s2_valid_q;
  wmf_pkg::meta_t   s2_meta_q;

  logic                       st_valid_q [NST+1];
  wmf_pkg::elems_t            st_elem_q  [NST+1];
  logic [wmf_pkg::NELEM-1:0]  st_alive_q [NST+1];
  logic [5:0]                 st_k_q     [NST+1];
  wmf_pkg::pix_t              st_res_q   [NST+1];
  wmf_pkg::meta_t             st_meta_q  [NST+1];

  logic [wmf_pkg::NELEM-1:0]  nx_alive [NST];
  logic [5:0]                 nx_k     [NST];
  wmf_pkg::pix_t              nx_res   [NST];

  // one result bit per stage, MSB first: keep the half holding the wanted rank
  always_comb begin
    logic [wmf_pkg::NELEM-1:0] bits;
    logic [5:0]                cnt0;
    for (int j = 0; j < NST; j++) begin
      for (int e = 0; e < wmf_pkg::NELEM; e++) bits[e] = st_elem_q[j][e][NST-1-j];
      cnt0 = 6'($countones(st_alive_q[j] & ~bits));
      nx_res[j] = st_res_q[j];
      if (st_k_q[j] < cnt0) begin
        nx_alive[j] = st_alive_q[j] & ~bits;
        nx_k[j]     = st_k_q[j];
        nx_res[j][NST-1-j] = 1'b0;
      end else begin
        nx_alive[j] = st_alive_q[j] & bits;
        nx_k[j]     = st_k_q[j] - cnt0;
        nx_res[j][NST-1-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      for (int j = 0; j <= NST; j++) st_valid_q[j] <= 1'b0;
    end else begin
      s2_valid_q    <= col_valid_i && emit_i;
      st_valid_q[0] <= s2_valid_q;
      for (int j = 0; j < NST; j++) st_valid_q[j+1] <= st_valid_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_valid_i) begin
      win_q[0] <= col_i;
      for (int c = 1; c < wmf_pkg::WIN; c++) win_q[c] <= win_q[c-1];
      s2_meta_q <= meta_i;
    end
    for (int dc = 0; dc < wmf_pkg::WIN; dc++) begin
      for (int dr = 0; dr < wmf_pkg::WIN; dr++) begin
        st_elem_q[0][dc*wmf_pkg::WIN+dr] <= win_q[dc][dr];
      end
    end
    st_alive_q[0] <= wmf_pkg::window_mask(half_i);
    st_k_q[0]     <= wmf_pkg::median_rank(half_i);
    st_res_q[0]   <= '0;
    st_meta_q[0]  <= s2_meta_q;
    for (int j = 0; j < NST; j++) begin
      st_elem_q[j+1]  <= st_elem_q[j];
      st_alive_q[j+1] <= nx_alive[j];
      st_k_q[j+1]     <= nx_k[j];
      st_res_q[j+1]   <= nx_res[j];
      st_meta_q[j+1]  <= st_meta_q[j];
    end
  end

  assign res_valid_o = st_valid_q[NST];
  assign res_o.value = st_meta_q[NST].border ? '0 : st_res_q[NST];
  assign res_o.col   = st_meta_q[NST].col;
  assign res_o.row   = st_meta_q[NST].row;
  assign res_o.last  = st_meta_q[NST].last;

endmodule

// File: hw/rtl/wmf_fifo.sv
module wmf_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             reserve_i,
  input  logic             wr_i,
  input  wmf_pkg::result_t data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic             full_o,
  output wmf_pkg::result_t data_o
);

  localparam int DEPTH = wmf_pkg::FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  wmf_pkg::result_t mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CNTW-1:0]  count_q, count_d, inflight_q, inflight_d;
  logic             rd;

  assign rd      = pop_i && (count_q != '0);
  assign empty_o = (count_q == '0);
  // words still in the pipeline hold their slot
  assign full_o  = ({1'b0, count_q} + {1'b0, inflight_q}) >= (CNTW+1)'(DEPTH);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    count_d    = count_q + CNTW'(wr_i) - CNTW'(rd);
    inflight_d = inflight_q + CNTW'(reserve_i) - CNTW'(wr_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q     <= '0;
      rptr_q     <= '0;
      count_q    <= '0;
      inflight_q <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + 1'b1;
      if (rd)   rptr_q <= rptr_q + 1'b1;
      count_q    <= count_d;
      inflight_q <= inflight_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> count_q != CNTW'(DEPTH))
    else $error("result queue written while full");
  a_credit_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> inflight_q != '0)
    else $error("word arrived without a reserved slot");
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, count_q} + {1'b0, inflight_q}) <= (CNTW+1)'(DEPTH))
    else $error("queue credit exceeded");

endmodule

// File: hw/rtl/window_median_image_filter.sv
// A pixel's word passes the front registers, the window register and the median stages.
// Throughput: one pixel per cycle unless full, set by the single-port line store
// banks and the eight-stage bit-slice median pipeline; a 16-word result queue
// absorbs pop stalls. Pixels that complete no window position cause no word.
// Reset: counters and valid bits clear, registers go to 512, 512, 5; the line store
// is not cleared and needs no clearing pass.
module window_median_image_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wmf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wmf_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    pixel_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    value_o,
  output logic [9:0]                    out_col_o,
  output logic [9:0]                    out_row_o,
  output logic                          frame_last_o
);

  logic             accept, full_int, emit_now;
  logic             col_valid, emit, res_valid;
  wmf_pkg::column_t col;
  wmf_pkg::meta_t   meta;
  logic [1:0]       half;
  wmf_pkg::result_t res, head;

  assign accept = push && !full_int;
  assign full   = full_int;

  wmf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .accept_i(accept), .pixel_i, .emit_now_o(emit_now),
    .col_valid_o(col_valid), .col_o(col), .emit_o(emit), .meta_o(meta), .half_o(half)
  );

  wmf_median u_median (
    .clk_i, .rst_ni,
    .col_valid_i(col_valid), .col_i(col), .emit_i(emit), .meta_i(meta), .half_i(half),
    .res_valid_o(res_valid), .res_o(res)
  );

  // only pixels that will produce a word hold a queue slot
  wmf_fifo u_fifo (
    .clk_i, .rst_ni,
    .reserve_i(accept && emit_now), .wr_i(res_valid), .data_i(res),
    .pop_i(pop), .empty_o(empty), .full_o(full_int), .data_o(head)
  );

  assign value_o      = head.value;
  assign out_col_o    = head.col;
  assign out_row_o    = head.row;
  assign frame_last_o = head.last;

endmodule
